### design/mtqdl_pkg.sv
`timescale 1ns / 1ps

package mtqdl_pkg;

    localparam int FIELD_W   = 32;
    localparam int DIPOLE_W  = 24;
    localparam int LIMIT_W   = 23;
    localparam int GAIN_W    = 32;
    localparam int SQ_W      = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;
    localparam int IN_W      = 7 * FIELD_W;
    localparam int OUT_W     = 3 * DIPOLE_W;
    localparam int QUOT_W    = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIPOLE_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FIELD_SQ = 2'd3;

    localparam logic              MODE_OMEGA_CROSS_B = 1'b0;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 32'd65536;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 23'd13107;
    localparam logic [SQ_W-1:0]    MIN_SQ_RESET = 64'd1;

    typedef logic signed [FIELD_W-1:0]  field_t;
    typedef logic signed [DIPOLE_W-1:0] dipole_t;

    function automatic logic dipole_within(input dipole_t d, input logic [LIMIT_W-1:0] lim);
        logic signed [DIPOLE_W:0] dw;
        logic signed [DIPOLE_W:0] lw;
        dw = {d[DIPOLE_W-1], d};
        lw = {2'b00, lim};
        return (dw <= lw) && (dw >= -lw);
    endfunction

endpackage

### design/magnetorquer_detumble_law_core.sv
`timescale 1ns / 1ps
// channel | direction | handshake       | payload
// s       | in        | s_tvalid/tready | s_tdata: rates, fields, sample_time
// m       | out       | m_tvalid/tready | m_tdata: dipoles; m_tuser: field_too_weak
// cfg     | in        | wr_en           | wr_index, wr_data
// Omega-cross-B items use the 24-step restoring divider, run at most once per axis,
// and the shared 33x33 multiplier for squares, cross products and gain.
// B-dot and weak-field items stop after the squared-field sum.
// One item at a time; the next is taken while a finished result waits at m.
// rst_n is asynchronous; it clears control state, configuration registers and field memory.

module magnetorquer_detumble_law_core
    import mtqdl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // rate_x, rate_y, rate_z, field_x, field_y, field_z, sample_time
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // dipole_x, dipole_y, dipole_z
    output logic [OUT_W-1:0]     m_tdata,
    // field_too_weak
    output logic                 m_tuser,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_DAT_W-1:0] wr_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ    = 4'd1;
    localparam logic [3:0] ST_CHK   = 4'd2;
    localparam logic [3:0] ST_X1    = 4'd3;
    localparam logic [3:0] ST_X2    = 4'd4;
    localparam logic [3:0] ST_G1    = 4'd5;
    localparam logic [3:0] ST_G2    = 4'd6;
    localparam logic [3:0] ST_OVF   = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_STORE = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]          state_reg;
    logic                ph_reg;
    logic [1:0]          idx_reg;
    logic [4:0]          cnt_reg;

    logic                mode_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [SQ_W-1:0]     min_sq_reg;

    field_t              last_field_reg [3];
    logic [FIELD_W-1:0]  last_time_reg;

    field_t              w_reg [3];
    field_t              b_reg [3];
    logic [FIELD_W-1:0]  time_reg;
    logic signed [64:0]  prod_reg;
    logic [SQ_W-1:0]     s_reg;
    logic signed [63:0]  t_reg;
    logic [63:0]         c_reg;
    logic                neg_reg;
    logic [95:0]         n_reg;
    logic [63:0]         rem_reg;
    logic [QUOT_W-1:0]   bits_reg;
    logic [QUOT_W-1:0]   q_reg;
    dipole_t             res_reg [3];
    logic                weak_reg;

    logic                out_valid_reg;
    dipole_t             out_reg [3];
    logic                out_weak_reg;

    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [65:0]  mul_full;
    logic signed [64:0]  diff;
    logic [64:0]         rem_sh;
    logic [64:0]         rem_sub;
    logic                rem_ge;
    logic [63:0]         rem_next;
    logic [LIMIT_W-1:0]  m_next;
    dipole_t             store_next;
    logic [LIMIT_W-1:0]  bdot_mag;
    logic                adv;
    dipole_t             bdot_next [3];
    logic                load_out;

    always_comb
    begin
        case (state_reg)
            ST_SQ:
            begin
                mul_a = {b_reg[0][31], b_reg[0]};
                mul_b = {b_reg[0][31], b_reg[0]};
            end
            ST_X1:
            begin
                mul_a = {w_reg[1][31], w_reg[1]};
                mul_b = {b_reg[2][31], b_reg[2]};
            end
            ST_X2:
            begin
                mul_a = {w_reg[2][31], w_reg[2]};
                mul_b = {b_reg[1][31], b_reg[1]};
            end
            ST_G1:
            begin
                mul_a = {1'b0, c_reg[31:0]};
                mul_b = {1'b0, gain_reg};
            end
            ST_G2:
            begin
                mul_a = {1'b0, c_reg[63:32]};
                mul_b = {1'b0, gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign diff     = {t_reg[63], t_reg} - {prod_reg[63], prod_reg[63:0]};

    assign rem_sh   = {rem_reg, bits_reg[QUOT_W-1]};
    assign rem_sub  = rem_sh - {1'b0, s_reg};
    assign rem_ge   = rem_sh >= {1'b0, s_reg};
    assign rem_next = rem_ge ? rem_sub[63:0] : rem_sh[63:0];

    assign m_next     = (q_reg > {1'b0, limit_reg}) ? limit_reg : q_reg[LIMIT_W-1:0];
    assign store_next = neg_reg ? -{1'b0, m_next} : {1'b0, m_next};

    assign bdot_mag = (gain_reg < {9'd0, limit_reg}) ? gain_reg[LIMIT_W-1:0] : limit_reg;
    assign adv      = time_reg > last_time_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (adv && (b_reg[i] > last_field_reg[i]))
                bdot_next[i] = -{1'b0, bdot_mag};
            else if (adv && (b_reg[i] < last_field_reg[i]))
                bdot_next[i] = {1'b0, bdot_mag};
            else
                bdot_next[i] = '0;
        end
    end

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE);

    // control state, configuration and field memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            mode_reg      <= MODE_OMEGA_CROSS_B;
            gain_reg      <= GAIN_RESET;
            limit_reg     <= LIMIT_RESET;
            min_sq_reg    <= MIN_SQ_RESET;
            for (int i = 0; i < 3; i++)
                last_field_reg[i] <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_CONTROL_MODE: mode_reg   <= wr_data[0];
                    REG_CONTROL_GAIN: gain_reg   <= wr_data[GAIN_W-1:0];
                    REG_DIPOLE_LIMIT: limit_reg  <= wr_data[LIMIT_W-1:0];
                    REG_MIN_FIELD_SQ: min_sq_reg <= wr_data;
                    default: ;
                endcase
            end

            out_valid_reg <= load_out || (out_valid_reg && !m_tready);

            case (state_reg)
                ST_IDLE:
                begin
                    ph_reg  <= 1'b0;
                    idx_reg <= '0;
                    if (s_tvalid)
                        state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd2)
                            state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    idx_reg <= '0;
                    if (s_reg < min_sq_reg)
                        state_reg <= ST_DONE;
                    else if (mode_reg != MODE_OMEGA_CROSS_B)
                    begin
                        for (int i = 0; i < 3; i++)
                            last_field_reg[i] <= b_reg[i];
                        last_time_reg <= time_reg;
                        state_reg     <= ST_DONE;
                    end
                    else
                        state_reg <= ST_X1;
                end
                ST_X1:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                        state_reg <= ST_X2;
                end
                ST_X2:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                        state_reg <= ST_G1;
                end
                ST_G1:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                        state_reg <= ST_G2;
                end
                ST_G2:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                        state_reg <= ST_OVF;
                end
                ST_OVF:
                begin
                    cnt_reg <= '0;
                    if ((s_reg == '0) || (n_reg[95:16] >= {16'd0, s_reg}))
                        state_reg <= ST_STORE;
                    else
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(QUOT_W - 1))
                        state_reg <= ST_STORE;
                end
                ST_STORE:
                begin
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg == 2'd2)
                        state_reg <= ST_DONE;
                    else
                        state_reg <= ST_X1;
                end
                ST_DONE:
                begin
                    if (load_out)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[64:0];

        if (load_out)
        begin
            for (int i = 0; i < 3; i++)
                out_reg[i] <= res_reg[i];
            out_weak_reg <= weak_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    w_reg[i] <= s_tdata[i*FIELD_W +: FIELD_W];
                    b_reg[i] <= s_tdata[(i+3)*FIELD_W +: FIELD_W];
                end
                time_reg <= s_tdata[6*FIELD_W +: FIELD_W];
                s_reg    <= '0;
            end
            ST_SQ:
            begin
                if (ph_reg)
                begin
                    s_reg    <= s_reg + prod_reg[63:0];
                    b_reg[0] <= b_reg[1];
                    b_reg[1] <= b_reg[2];
                    b_reg[2] <= b_reg[0];
                end
            end
            ST_CHK:
            begin
                weak_reg <= s_reg < min_sq_reg;
                for (int i = 0; i < 3; i++)
                begin
                    if (s_reg < min_sq_reg)
                        res_reg[i] <= '0;
                    else
                        res_reg[i] <= bdot_next[i];
                end
            end
            ST_X1:
            begin
                if (ph_reg)
                    t_reg <= prod_reg[63:0];
            end
            ST_X2:
            begin
                if (ph_reg)
                begin
                    neg_reg <= diff[64];
                    c_reg   <= diff[64] ? 64'(-diff) : diff[63:0];
                end
            end
            ST_G1:
            begin
                if (ph_reg)
                    n_reg <= {32'd0, prod_reg[63:0]};
            end
            ST_G2:
            begin
                if (ph_reg)
                    n_reg <= n_reg + {prod_reg[63:0], 32'd0};
            end
            ST_OVF:
            begin
                rem_reg  <= n_reg[79:16];
                bits_reg <= {n_reg[15:0], 8'd0};
                if (s_reg == '0)
                    q_reg <= '0;
                else
                    q_reg <= '1;
            end
            ST_DIV:
            begin
                rem_reg  <= rem_next;
                bits_reg <= {bits_reg[QUOT_W-2:0], 1'b0};
                q_reg    <= {q_reg[QUOT_W-2:0], rem_ge};
            end
            ST_STORE:
            begin
                res_reg[0] <= res_reg[1];
                res_reg[1] <= res_reg[2];
                res_reg[2] <= store_next;
                w_reg[0]   <= w_reg[1];
                w_reg[1]   <= w_reg[2];
                w_reg[2]   <= w_reg[0];
                b_reg[0]   <= b_reg[1];
                b_reg[1]   <= b_reg[2];
                b_reg[2]   <= b_reg[0];
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg[2], out_reg[1], out_reg[0]};
    assign m_tuser  = out_weak_reg;

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    a_weak_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("weak field result not zero");

    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> dipole_within(out_reg[0], limit_reg) &&
                     dipole_within(out_reg[1], limit_reg) &&
                     dipole_within(out_reg[2], limit_reg))
        else $error("dipole beyond limit");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < s_reg)
        else $error("divider remainder out of range");
`endif

endmodule

### tb/tb_magnetorquer_detumble_law_core.sv
`timescale 1ns / 1ps

module tb_magnetorquer_detumble_law_core;
    import mtqdl_pkg::*;

    localparam logic   MODE_BDOT   = 1'b1;
    localparam field_t FMAX        = 32'sh7FFFFFFF;
    localparam field_t FMIN        = 32'sh80000000;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     CALM_TAIL   = 120;

    typedef struct {
        dipole_t dip [3];
        logic    too_weak;
    } dipole_cmd_t;

    typedef struct {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] val;
        logic [IN_W-1:0]      sample;
    } feed_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tuser;
    logic                 wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index = '0;
    logic [CFG_DAT_W-1:0] wr_data = '0;

    magnetorquer_detumble_law_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of settings and field memory
    logic               cfg_mode   = MODE_OMEGA_CROSS_B;
    logic [GAIN_W-1:0]  cfg_gain   = GAIN_RESET;
    logic [LIMIT_W-1:0] cfg_limit  = LIMIT_RESET;
    logic [SQ_W-1:0]    cfg_min_sq = MIN_SQ_RESET;
    field_t             last_fld [3] = '{0, 0, 0};
    logic [31:0]        last_tick = '0;

    feed_t       feed [$];
    dipole_cmd_t cmd_expected [$];
    int          samples_total = 0;
    int          samples_sent = 0;
    int          samples_checked = 0;
    int          calm_from = 0;
    int          mismatches = 0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          settle = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    string       axis_name [3] = '{"dipole_x", "dipole_y", "dipole_z"};

    function automatic dipole_cmd_t detumble_command(input logic [IN_W-1:0] smp);
        dipole_cmd_t        r;
        logic signed [63:0] w [3];
        logic signed [63:0] b [3];
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [64:0] c;
        logic [63:0]        s;
        logic [63:0]        cmag;
        logic [127:0]       q;
        logic [31:0]        t;
        logic [23:0]        m;
        logic               neg;
        s = '0;
        t = smp[6*FIELD_W +: FIELD_W];
        for (int k = 0; k < 3; k++)
        begin
            w[k] = field_t'(smp[k*FIELD_W +: FIELD_W]);
            b[k] = field_t'(smp[(k+3)*FIELD_W +: FIELD_W]);
            s = s + 64'(b[k] * b[k]);
            r.dip[k] = '0;
        end
        r.too_weak = 1'b0;
        if (s < cfg_min_sq)
        begin
            r.too_weak = 1'b1;
            return r;
        end
        if (cfg_mode == MODE_OMEGA_CROSS_B)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p1 = w[(k+1)%3] * b[(k+2)%3];
                p2 = w[(k+2)%3] * b[(k+1)%3];
                c = p1 - p2;
                neg = c[64];
                cmag = neg ? 64'(-c) : 64'(c);
                m = '0;
                if (s != 0 && cmag != 0)
                begin
                    q = ({64'd0, cmag} * {96'd0, cfg_gain}) << 8;
                    q = q / {64'd0, s};
                    m = (q > {105'd0, cfg_limit}) ? {1'b0, cfg_limit} : q[23:0];
                end
                r.dip[k] = neg ? -m : m;
            end
        end
        else
        begin
            m = (cfg_gain < {9'd0, cfg_limit}) ? cfg_gain[23:0] : {1'b0, cfg_limit};
            for (int k = 0; k < 3; k++)
            begin
                if (t > last_tick)
                begin
                    if (b[k] > last_fld[k])
                        r.dip[k] = -m;
                    else if (b[k] < last_fld[k])
                        r.dip[k] = m;
                end
                last_fld[k] = b[k][31:0];
            end
            last_tick = t;
        end
        return r;
    endfunction

    task automatic add_sample(input field_t rx, input field_t ry, input field_t rz,
                              input field_t fx, input field_t fy, input field_t fz,
                              input logic [31:0] tk);
        feed_t f;
        f.is_write = 1'b0;
        f.idx = '0;
        f.val = '0;
        f.sample = {tk, fz, fy, fx, rz, ry, rx};
        feed.push_back(f);
        samples_total++;
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
        feed_t f;
        f.is_write = 1'b1;
        f.idx = idx;
        f.val = v;
        f.sample = '0;
        feed.push_back(f);
    endtask

    // junk above the register width must be dropped by the block
    function automatic logic [63:0] pad_noise(input logic [63:0] v, input int w);
        logic [63:0] mask;
        mask = (64'd1 << w) - 1;
        return (v & mask) | ({$urandom, $urandom} & ~mask);
    endfunction

    function automatic field_t rand_word();
        field_t v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: return v;
            1: return field_t'($urandom_range(0, 4)) - 2;
            2: return $urandom_range(0, 1) ? FMAX : FMIN;
            default: return v >>> $urandom_range(0, 31);
        endcase
    endfunction

    // driver: samples on s, register writes only once the block has drained
    always @(posedge clk)
    begin : drive
        feed_t head;
        logic  nv;
        logic  nw;
        nv = s_tvalid;
        nw = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                cmd_expected.push_back(detumble_command(s_tdata));
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (src_gap != 0)
                    src_gap--;
                else if (feed.size() != 0)
                begin
                    head = feed[0];
                    if (head.is_write)
                    begin
                        settle = (cmd_expected.size() == 0) ? settle + 1 : 0;
                        if (settle >= 4)
                        begin
                            void'(feed.pop_front());
                            nw = 1'b1;
                            wr_index <= head.idx;
                            wr_data <= head.val;
                            case (head.idx)
                                REG_CONTROL_MODE: cfg_mode = head.val[0];
                                REG_CONTROL_GAIN: cfg_gain = head.val[GAIN_W-1:0];
                                REG_DIPOLE_LIMIT: cfg_limit = head.val[LIMIT_W-1:0];
                                REG_MIN_FIELD_SQ: cfg_min_sq = head.val[SQ_W-1:0];
                                default: ;
                            endcase
                        end
                    end
                    else
                    begin
                        void'(feed.pop_front());
                        settle = 0;
                        s_tdata <= head.sample;
                        nv = 1'b1;
                        samples_sent++;
                        if (samples_sent >= calm_from)
                            calm = 1'b1;
                        if (!calm && $urandom_range(0, 3) == 0)
                            src_gap = $urandom_range(1, 6);
                    end
                end
            end
        end
        s_tvalid <= nv;
        wr_en <= nw;
    end

    // monitor: stalls m and checks each dipole command
    always @(posedge clk)
    begin : watch
        dipole_cmd_t want;
        dipole_t     got;
        logic        nr;
        nr = m_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                samples_checked++;
                if (cmd_expected.size() == 0)
                begin
                    $error("dipole command transaction with none pending");
                    mismatches++;
                end
                else
                begin
                    want = cmd_expected.pop_front();
                    for (int k = 0; k < 3; k++)
                    begin
                        got = m_tdata[k*DIPOLE_W +: DIPOLE_W];
                        if (got !== want.dip[k])
                        begin
                            $error("%s expected %0d got %0d", axis_name[k], want.dip[k], got);
                            mismatches++;
                        end
                    end
                    if (m_tuser !== want.too_weak)
                    begin
                        $error("field_too_weak expected %0d got %0d", want.too_weak, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (sink_gap != 0)
            begin
                sink_gap--;
                nr = 1'b0;
            end
            else
            begin
                nr = 1'b1;
                if (!calm && $urandom_range(0, 4) == 0)
                    sink_gap = $urandom_range(1, 6);
            end
        end
        m_tready <= nr;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        field_t      fld [3];
        field_t      rt [3];
        logic [31:0] tick;
        logic [63:0] v;

        // reset settings: omega cross B, unity gain, threshold 1
        add_sample(0, 0, 0, 0, 0, 0, 0);
        add_sample(FMAX, FMAX, FMAX, FMIN, FMIN, FMIN, 1);
        add_sample(FMAX, FMIN, 0, FMIN, FMAX, 1, 2);
        add_sample(0, 0, 1, 32'sh100000, 0, 0, 3);
        add_sample(-1, 1, 32'sh12345, FMAX, FMIN, FMAX, 4);
        add_sample(0, 0, 0, 1, 0, 0, 5);
        add_write(REG_MIN_FIELD_SQ, 64'd0);
        add_sample(FMAX, FMIN, 7, 0, 0, 0, 6);
        add_write(REG_CONTROL_GAIN, 64'hFFFF_FFFF);
        add_write(REG_DIPOLE_LIMIT, 64'h7F_FFFF);
        add_sample(3, -200, 1000, 32'sh40000000, -32'sh300, 32'sh7000, 7);
        add_write(REG_CONTROL_GAIN, 64'd0);
        add_sample(FMAX, FMIN, FMAX, 1000, -1000, 5, 8);
        // B-dot: stale time, steps, unchanged axes, weak field holds memory
        add_write(REG_CONTROL_MODE, 64'(MODE_BDOT));
        add_write(REG_CONTROL_GAIN, 64'h4000);
        add_write(REG_MIN_FIELD_SQ, 64'd1);
        add_sample(0, 0, 0, 5, -5, 0, 0);
        add_sample(0, 0, 0, 6, -6, 0, 10);
        add_sample(0, 0, 0, 7, -7, 1, 10);
        add_sample(0, 0, 0, 0, 0, 0, 20);
        add_sample(FMAX, FMIN, 0, 7, -8, 1, 15);
        add_sample(0, 0, 0, FMAX, FMIN, FMAX, 32'hFFFF_FFFF);
        add_sample(0, 0, 0, FMIN, FMAX, FMIN, 5);
        // memory survives a mode round trip
        add_write(REG_CONTROL_MODE, 64'(MODE_OMEGA_CROSS_B));
        add_sample(1, 2, 3, 100, 200, 300, 6);
        add_write(REG_CONTROL_MODE, 64'(MODE_BDOT));
        add_write(REG_DIPOLE_LIMIT, 64'h100);
        add_sample(0, 0, 0, FMAX, FMAX, FMAX, 7);
        add_write(REG_DIPOLE_LIMIT, 64'd0);
        add_sample(0, 0, 0, 1, 2, 3, 8);
        add_write(REG_MIN_FIELD_SQ, 64'hFFFF_FFFF_FFFF_FFFF);
        add_sample(FMAX, FMAX, FMAX, FMIN, FMIN, FMIN, 9);

        fld = '{0, 0, 0};
        tick = 32'd9;
        for (int ph = 0; ph < 10; ph++)
        begin
            add_write(REG_CONTROL_MODE, pad_noise(64'($urandom_range(0, 1)), 1));
            case ($urandom_range(0, 4))
                0: v = 64'd0;
                1: v = 64'hFFFF_FFFF;
                2: v = 64'($urandom);
                3: v = 64'($urandom_range(0, 262144));
                default: v = 64'($urandom >> $urandom_range(0, 31));
            endcase
            add_write(REG_CONTROL_GAIN, pad_noise(v, GAIN_W));
            case ($urandom_range(0, 4))
                0: v = 64'd0;
                1: v = 64'h7F_FFFF;
                default: v = 64'($urandom >> $urandom_range(9, 31));
            endcase
            add_write(REG_DIPOLE_LIMIT, pad_noise(v, LIMIT_W));
            case ($urandom_range(0, 9))
                0: v = 64'd0;
                1: v = 64'd1;
                2: v = 64'hFFFF_FFFF_FFFF_FFFF;
                default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            endcase
            add_write(REG_MIN_FIELD_SQ, v);
            for (int n = 0; n < 110; n++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    case ($urandom_range(0, 3))
                        0: fld[a] = fld[a];
                        1: fld[a] = fld[a] + field_t'($urandom_range(0, 6)) - 3;
                        default: fld[a] = rand_word();
                    endcase
                    rt[a] = rand_word();
                end
                if ($urandom_range(0, 39) == 0)
                    tick = $urandom;
                else
                    tick = tick + $urandom_range(0, 4);
                add_sample(rt[0], rt[1], rt[2], fld[0], fld[1], fld[2], tick);
            end
        end
        calm_from = samples_total - CALM_TAIL;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (samples_checked < samples_total)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && cmd_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
